// File: hdl/brcp_pkg.sv
// Shared types, widths and codes of the block range chunk planner.
package brcp_pkg;

  localparam int unsigned ADDR_W       = 48;
  localparam int unsigned ADDR_X       = ADDR_W + 1;
  localparam int unsigned LEN_W        = 24;
  localparam int unsigned OFF_W        = 16;
  localparam int unsigned BYTES_W      = 17;
  localparam int unsigned POS_W        = 21;
  localparam int unsigned SHIFT_W      = 5;
  localparam int unsigned LIMIT_BLOCKS = 31;
  localparam int unsigned IN_DATA_W    = 128;
  localparam int unsigned OUT_DATA_W   = 176;

  localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 5'd6;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 5'd16;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd12;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_ZERO  = 2'd2,
    OP_COPY  = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ACT_FETCH = 3'd0,
    ACT_DATA  = 3'd1,
    ACT_ZERO  = 3'd2,
    ACT_REUSE = 3'd3,
    ACT_NONE  = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EMIT,
    ST_SINGLE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic check;
    logic step;
    logic single;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic error;
    logic final_chunk;
    logic slot_free;
  } stat_t;

  // One result, last field in the lowest bits
  typedef struct packed {
    logic               request_error;
    logic               backward;
    logic               source_fetch;
    action_e            target_action;
    logic [POS_W-1:0]   buffer_position;
    logic [BYTES_W-1:0] chunk_bytes;
    logic [OFF_W-1:0]   source_offset;
    logic [ADDR_W-1:0]  source_block;
    logic [OFF_W-1:0]   target_offset;
    logic [ADDR_W-1:0]  target_block;
  } result_t;

endpackage

// File: hdl/block_range_chunk_planner.sv
// Top level of the block range chunk planner: stream ports and field packing.
//
//   channel  | direction | payload
//   ---------+-----------+---------------------------------------------------
//   s_axis   | in        | one request (command, address, source, length)
//   m_axis   | out       | one chunk result per item, tlast on the final one
//   cfg      | in        | block_shift register write
//
// A request yields N results, N being the number of chunks (1 for an empty or
// refused request, at most 63). The request is captured, then checked; then
// the chunk stepper in the datapath produces one chunk per cycle, unless the
// result side stalls, through a single result register.
// A new request is accepted only once the previous one has written its last
// result; that result may still wait in the output register.
// Reset sets block_shift to 12 and empties the output register. Low
// m_axis_tready with a result waiting holds the stepper and the result register.
module block_range_chunk_planner (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // command[1:0], address[49:2], source_address[97:50], length[121:98], zeros
  input  logic [brcp_pkg::IN_DATA_W-1:0]       s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // target_block[47:0], target_offset[63:48], source_block[111:64],
  // source_offset[127:112], chunk_bytes[144:128], buffer_position[165:145],
  // target_action[168:166], source_fetch[169], backward[170],
  // request_error[171], zeros
  output logic [brcp_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  output logic                                 m_axis_tlast_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [brcp_pkg::SHIFT_W-1:0]         cfg_data_i
);
  import brcp_pkg::*;

  localparam int unsigned RES_W = $bits(result_t);

  cmd_t    cmd;
  stat_t   stat;
  result_t result;
  opcode_e command;

  assign command     = opcode_e'(s_axis_tdata_i[1:0]);
  assign cfg_ready_o = 1'b1;

  brcp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  brcp_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i),
    .cfg_data_i       (cfg_data_i),
    .command_i        (command),
    .address_i        (s_axis_tdata_i[49:2]),
    .source_address_i (s_axis_tdata_i[97:50]),
    .length_i         (s_axis_tdata_i[121:98]),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .out_result_o     (result),
    .out_last_o       (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {{(OUT_DATA_W - RES_W){1'b0}}, result};

endmodule

// File: hdl/brcp_ctrl.sv
// Request sequencer of the block range chunk planner.
module brcp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  brcp_pkg::stat_t stat_i,
  output brcp_pkg::cmd_t  cmd_o
);
  import brcp_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat_i.empty || stat_i.error) state_d = ST_SINGLE;
        else state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat_i.slot_free && stat_i.final_chunk) state_d = ST_IDLE;
      end
      ST_SINGLE: begin
        if (stat_i.slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.step = stat_i.slot_free;
      end
      ST_SINGLE: begin
        cmd_o.single = stat_i.slot_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  a_step_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.step || cmd_o.single) |-> stat_i.slot_free)
    else $error("result written while output slot is occupied");

  a_final_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.step && stat_i.final_chunk) |=> state_q == ST_IDLE)
    else $error("sequencer did not return to idle after final chunk");

  a_load_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_CHECK && !in_ready_o))
    else $error("accepted request not checked in next cycle");

endmodule

// File: hdl/brcp_datapath.sv
// Request registers, chunk stepping arithmetic and result register of the planner.
module brcp_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [brcp_pkg::SHIFT_W-1:0]  cfg_data_i,
  input  brcp_pkg::opcode_e             command_i,
  input  logic [brcp_pkg::ADDR_W-1:0]   address_i,
  input  logic [brcp_pkg::ADDR_W-1:0]   source_address_i,
  input  logic [brcp_pkg::LEN_W-1:0]    length_i,
  input  brcp_pkg::cmd_t                cmd_i,
  output brcp_pkg::stat_t               stat_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output brcp_pkg::result_t             out_result_o,
  output logic                          out_last_o
);
  import brcp_pkg::*;

  // Configuration, stored already clamped
  logic [SHIFT_W-1:0] shift_q;

  // Captured request
  opcode_e            op_q;
  logic [ADDR_W-1:0]  dst_q, src_q;
  logic [LEN_W-1:0]   len_q;

  // Walk state
  logic [ADDR_W-1:0]  d_q, s_q;
  logic [LEN_W-1:0]   rem_q;
  logic [POS_W-1:0]   pos_q;
  logic               first_q, back_q, zero_ok_q, err_q;

  // Result register
  logic               out_valid_q;
  result_t            res_q, res_d;
  logic               last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= SHIFT_RESET;
    end else if (cfg_we_i) begin
      if (cfg_data_i < SHIFT_MIN) shift_q <= SHIFT_MIN;
      else if (cfg_data_i > SHIFT_MAX) shift_q <= SHIFT_MAX;
      else shift_q <= cfg_data_i;
    end
  end

  // Request checks
  logic               is_copy;
  logic [ADDR_X-1:0]  dst_end, src_end;
  logic [LEN_W-1:0]   len_lim;
  logic [ADDR_W-1:0]  gap;
  logic               req_empty, req_err, req_back, req_zero_ok;
  logic               dst_over, src_over;

  always_comb begin
    is_copy     = (op_q == OP_COPY);
    dst_end     = {1'b0, dst_q} + ADDR_X'(len_q);
    src_end     = {1'b0, src_q} + ADDR_X'(len_q);
    len_lim     = LEN_W'(LIMIT_BLOCKS) << shift_q;
    dst_over    = dst_end[ADDR_W] && (dst_end[ADDR_W-1:0] != '0);
    src_over    = src_end[ADDR_W] && (src_end[ADDR_W-1:0] != '0);
    req_empty   = (len_q == '0) || (is_copy && (src_q == dst_q));
    req_err     = (len_q > len_lim) || dst_over || (is_copy && src_over);
    req_back    = is_copy && (src_q < dst_q) && (src_end > {1'b0, dst_q});
    gap         = (src_q > dst_q) ? (src_q - dst_q) : (dst_q - src_q);
    req_zero_ok = (gap >> shift_q) != '0;
  end

  // Chunk arithmetic
  logic [BYTES_W-1:0] bs, mask, span_s, span_d, span_min, n;
  logic [OFF_W-1:0]   offs, offd;
  logic [ADDR_W-1:0]  d_next, s_next, tgt_addr, srcp_addr;
  logic               final_chunk, new_d;
  action_e            act;

  always_comb begin
    bs   = BYTES_W'(1) << shift_q;
    mask = bs - BYTES_W'(1);
    offs = s_q[OFF_W-1:0] & mask[OFF_W-1:0];
    offd = d_q[OFF_W-1:0] & mask[OFF_W-1:0];
    if (back_q) begin
      span_s = (offs != '0) ? {1'b0, offs} : bs;
      span_d = (offd != '0) ? {1'b0, offd} : bs;
    end else begin
      span_s = is_copy ? (bs - {1'b0, offs}) : bs;
      span_d = bs - {1'b0, offd};
    end
    span_min    = (span_s < span_d) ? span_s : span_d;
    n           = (rem_q < LEN_W'(span_min)) ? rem_q[BYTES_W-1:0] : span_min;
    final_chunk = (LEN_W'(n) == rem_q);
    d_next      = back_q ? (d_q - ADDR_W'(n)) : (d_q + ADDR_W'(n));
    s_next      = back_q ? (s_q - ADDR_W'(n)) : (s_q + ADDR_W'(n));
    tgt_addr    = back_q ? d_next : d_q;
    srcp_addr   = back_q ? s_next : s_q;
    new_d       = first_q || (offd == '0);
    if (is_copy) begin
      if (!new_d) act = ACT_REUSE;
      else if (zero_ok_q && (offd == '0) && (rem_q >= LEN_W'(bs))) act = ACT_ZERO;
      else act = ACT_FETCH;
    end else if ((offd == '0) && (n == bs)) begin
      case (op_q)
        OP_READ:  act = ACT_FETCH;
        OP_WRITE: act = ACT_DATA;
        default:  act = ACT_ZERO;
      endcase
    end else begin
      act = ACT_FETCH;
    end
  end

  always_comb begin
    res_d = '0;
    res_d.target_action = ACT_NONE;
    if (cmd_i.step) begin
      res_d.target_block  = tgt_addr >> shift_q;
      res_d.target_offset = tgt_addr[OFF_W-1:0] & mask[OFF_W-1:0];
      res_d.chunk_bytes   = n;
      res_d.target_action = act;
      res_d.backward      = back_q;
      if (is_copy) begin
        res_d.source_block  = srcp_addr >> shift_q;
        res_d.source_offset = srcp_addr[OFF_W-1:0] & mask[OFF_W-1:0];
        res_d.source_fetch  = first_q || (offs == '0);
      end else if (op_q == OP_READ || op_q == OP_WRITE) begin
        res_d.buffer_position = pos_q;
      end
    end else begin
      res_d.request_error = err_q;
    end
  end

  // Request capture and walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= command_i;
      dst_q <= address_i;
      src_q <= source_address_i;
      len_q <= length_i;
    end
    if (cmd_i.check) begin
      // an empty request wins over the error checks
      err_q     <= req_err && !req_empty;
      back_q    <= req_back;
      zero_ok_q <= req_zero_ok;
      d_q       <= req_back ? dst_end[ADDR_W-1:0] : dst_q;
      s_q       <= req_back ? src_end[ADDR_W-1:0] : src_q;
      rem_q     <= len_q;
      pos_q     <= '0;
      first_q   <= 1'b1;
    end else if (cmd_i.step) begin
      d_q     <= d_next;
      s_q     <= s_next;
      rem_q   <= rem_q - LEN_W'(n);
      pos_q   <= pos_q + POS_W'(n);
      first_q <= 1'b0;
    end
    if (cmd_i.step || cmd_i.single) begin
      res_q  <= res_d;
      last_q <= cmd_i.single || final_chunk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step || cmd_i.single) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.empty       = req_empty;
  assign stat_o.error       = req_err;
  assign stat_o.final_chunk = final_chunk;
  assign stat_o.slot_free   = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_result_o = res_q;
  assign out_last_o   = last_q;

  a_step_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (rem_q != '0 && n != '0 && n <= bs))
    else $error("chunk step with empty remainder or bad chunk size");

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step || cmd_i.single) |=> out_valid_q)
    else $error("written result not presented");

  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (shift_q >= SHIFT_MIN) && (shift_q <= SHIFT_MAX))
    else $error("block shift outside clamped range");

endmodule

// File: tb/sv/brcp_chunk_checker.sv
// Chunk checker: plans the chunks of every accepted request and compares the results.
module brcp_chunk_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid_i,
  input  logic                            s_tready_i,
  input  logic [brcp_pkg::IN_DATA_W-1:0]  s_tdata_i,
  input  logic                            m_tvalid_i,
  input  logic                            m_tready_i,
  input  logic [brcp_pkg::OUT_DATA_W-1:0] m_tdata_i,
  input  logic                            m_tlast_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [brcp_pkg::SHIFT_W-1:0]    cfg_data_i,
  output int                              mismatches_o,
  output int                              pending_o,
  output int                              chunks_seen_o
);
  import brcp_pkg::*;

  typedef struct packed {
    logic    last;
    result_t fields;
  } planned_chunk_t;

  localparam logic [63:0] ADDR_TOP = 64'h1_0000_0000_0000;

  planned_chunk_t planned_chunks[$];
  logic [SHIFT_W-1:0] block_shift_q;
  int mismatches;
  int chunks_seen;

  assign mismatches_o  = mismatches;
  assign pending_o     = planned_chunks.size();
  assign chunks_seen_o = chunks_seen;

  function automatic logic [63:0] min_of3(input logic [63:0] a, b, c);
    logic [63:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  task automatic push_chunk(input logic [63:0] tblk, toff, sblk, soff, nbytes, pos,
                            input action_e act, input logic sfetch, bwd, err, last);
    planned_chunk_t c;
    c.last                   = last;
    c.fields.target_block    = tblk[ADDR_W-1:0];
    c.fields.target_offset   = toff[OFF_W-1:0];
    c.fields.source_block    = sblk[ADDR_W-1:0];
    c.fields.source_offset   = soff[OFF_W-1:0];
    c.fields.chunk_bytes     = nbytes[BYTES_W-1:0];
    c.fields.buffer_position = pos[POS_W-1:0];
    c.fields.target_action   = act;
    c.fields.source_fetch    = sfetch;
    c.fields.backward        = bwd;
    c.fields.request_error   = err;
    planned_chunks.push_back(c);
  endtask

  task automatic plan_chunks(input opcode_e op, input logic [ADDR_W-1:0] dst_a,
                             input logic [ADDR_W-1:0] src_a, input logic [LEN_W-1:0] len_a);
    logic [SHIFT_W-1:0] sh;
    logic [63:0] bs, msk, dst, src, len, a, s, d, rem, pos, n, off, offd, offs, gap;
    logic first, back, can_zero, newd, sfetch;
    action_e act;
    sh = (block_shift_q < SHIFT_MIN) ? SHIFT_MIN :
         (block_shift_q > SHIFT_MAX) ? SHIFT_MAX : block_shift_q;
    bs  = 64'd1 << sh;
    msk = bs - 64'd1;
    dst = 64'(dst_a);
    src = 64'(src_a);
    len = 64'(len_a);
    if (len == 64'd0 || (op == OP_COPY && src == dst)) begin
      push_chunk(64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, ACT_NONE, 1'b0, 1'b0, 1'b0, 1'b1);
    end else if (len > (64'(LIMIT_BLOCKS) << sh) || dst + len > ADDR_TOP ||
                 (op == OP_COPY && src + len > ADDR_TOP)) begin
      push_chunk(64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, ACT_NONE, 1'b0, 1'b0, 1'b1, 1'b1);
    end else if (op != OP_COPY) begin
      a   = dst;
      rem = len;
      pos = 64'd0;
      while (rem != 64'd0) begin
        off = a & msk;
        n   = bs - off;
        if (n > rem) n = rem;
        act = ACT_FETCH;
        // a whole block needs no fetch for a write or zero
        if (off == 64'd0 && n == bs)
          act = (op == OP_READ) ? ACT_FETCH : ((op == OP_WRITE) ? ACT_DATA : ACT_ZERO);
        push_chunk(a >> sh, off, 64'd0, 64'd0, n,
                   (op == OP_READ || op == OP_WRITE) ? pos : 64'd0,
                   act, 1'b0, 1'b0, 1'b0, rem == n);
        a   = a + n;
        pos = pos + n;
        rem = rem - n;
      end
    end else begin
      gap      = (src > dst) ? src - dst : dst - src;
      can_zero = gap >= bs;
      back     = !(src > dst || src + len <= dst);
      first    = 1'b1;
      s        = src;
      d        = dst;
      rem      = len;
      if (back) begin
        s = s + len;
        d = d + len;
      end
      while (rem != 64'd0) begin
        offd   = d & msk;
        offs   = s & msk;
        newd   = first || offd == 64'd0;
        sfetch = first || offs == 64'd0;
        act    = newd ? ((can_zero && offd == 64'd0 && rem >= bs) ? ACT_ZERO : ACT_FETCH)
                      : ACT_REUSE;
        if (!back) begin
          n = min_of3(bs - offs, bs - offd, rem);
          push_chunk(d >> sh, offd, s >> sh, offs, n, 64'd0, act, sfetch, 1'b0, 1'b0,
                     rem == n);
          s = s + n;
          d = d + n;
        end else begin
          // walk down: a zero offset means the whole block below
          n = min_of3((offs != 64'd0) ? offs : bs, (offd != 64'd0) ? offd : bs, rem);
          s = s - n;
          d = d - n;
          push_chunk(d >> sh, d & msk, s >> sh, s & msk, n, 64'd0, act, sfetch, 1'b1, 1'b0,
                     rem == n);
        end
        rem   = rem - n;
        first = 1'b0;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      if (mismatches < 10)
        $display("mismatch in %s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    planned_chunk_t exp_c;
    result_t got;
    if (!rst_ni) begin
      block_shift_q = SHIFT_RESET;
      planned_chunks.delete();
      mismatches  = 0;
      chunks_seen = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i)
        block_shift_q = cfg_data_i;
      // compare before planning so a fresh request never matches its own cycle
      if (m_tvalid_i && m_tready_i) begin
        chunks_seen++;
        if (planned_chunks.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result with nothing pending: %h", m_tdata_i);
          mismatches++;
        end else begin
          exp_c = planned_chunks.pop_front();
          got   = m_tdata_i[$bits(result_t)-1:0];
          check_field("target_block", 64'(exp_c.fields.target_block),
                      64'(got.target_block));
          check_field("target_offset", 64'(exp_c.fields.target_offset),
                      64'(got.target_offset));
          check_field("source_block", 64'(exp_c.fields.source_block),
                      64'(got.source_block));
          check_field("source_offset", 64'(exp_c.fields.source_offset),
                      64'(got.source_offset));
          check_field("chunk_bytes", 64'(exp_c.fields.chunk_bytes), 64'(got.chunk_bytes));
          check_field("buffer_position", 64'(exp_c.fields.buffer_position),
                      64'(got.buffer_position));
          check_field("target_action", 64'(exp_c.fields.target_action),
                      64'(got.target_action));
          check_field("source_fetch", 64'(exp_c.fields.source_fetch),
                      64'(got.source_fetch));
          check_field("backward", 64'(exp_c.fields.backward), 64'(got.backward));
          check_field("request_error", 64'(exp_c.fields.request_error),
                      64'(got.request_error));
          check_field("tlast", 64'(exp_c.last), 64'(m_tlast_i));
          check_field("padding", 64'd0, 64'(m_tdata_i[OUT_DATA_W-1:$bits(result_t)]));
        end
      end
      if (s_tvalid_i && s_tready_i)
        plan_chunks(opcode_e'(s_tdata_i[1:0]), s_tdata_i[49:2], s_tdata_i[97:50],
                    s_tdata_i[121:98]);
    end
  end

endmodule

// File: tb/sv/block_range_chunk_planner_tb.sv
// Testbench top of the block range chunk planner: stimulus, watchdog and verdict.
module block_range_chunk_planner_tb;
  import brcp_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int IDLE_LIMIT   = 3000;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 45;
  localparam logic [63:0] ADDR_TOP = 64'h1_0000_0000_0000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [SHIFT_W-1:0]    cfg_data;

  int mismatches;
  int pending;
  int chunks_seen;
  int requests_sent;
  int idle_cycles;
  logic calm;

  always #(HALF_PERIOD) clk = ~clk;

  block_range_chunk_planner dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data)
  );

  brcp_chunk_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_tvalid_i    (s_tvalid),
    .s_tready_i    (s_tready),
    .s_tdata_i     (s_tdata),
    .m_tvalid_i    (m_tvalid),
    .m_tready_i    (m_tready),
    .m_tdata_i     (m_tdata),
    .m_tlast_i     (m_tlast),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .mismatches_o  (mismatches),
    .pending_o     (pending),
    .chunks_seen_o (chunks_seen)
  );

  // result side stalls at random, never while calm
  always @(negedge clk) begin
    m_tready = calm || ($urandom_range(99) >= 15);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles, %0d results pending",
               idle_cycles, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] rand48();
    return {16'd0, 16'($urandom), $urandom};
  endfunction

  task automatic send_request(input opcode_e op, input logic [ADDR_W-1:0] dst,
                              input logic [ADDR_W-1:0] src, input logic [LEN_W-1:0] len);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 15) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {6'd0, len, src, dst, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_block_shift(input logic [SHIFT_W-1:0] value);
    wait_drained();
    repeat ($urandom_range(4)) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_request(input logic [SHIFT_W-1:0] shift_sel);
    logic [SHIFT_W-1:0] sh;
    logic [63:0] bs, lim, ln, d, s;
    int unsigned bs_u, lim_u, ln_u, r;
    opcode_e op;
    sh    = (shift_sel < SHIFT_MIN) ? SHIFT_MIN : (shift_sel > SHIFT_MAX) ? SHIFT_MAX : shift_sel;
    bs    = 64'd1 << sh;
    lim   = 64'(LIMIT_BLOCKS) << sh;
    bs_u  = 32'(bs);
    lim_u = 32'(lim);
    op    = opcode_e'($urandom_range(3));
    if ($urandom_range(99) < 8) begin
      // noise: every field at random, mostly refused
      d  = rand48();
      s  = rand48();
      ln = 64'($urandom) & 64'hFF_FFFF;
    end else begin
      r = $urandom_range(99);
      if (r < 6)       ln = 64'd0;
      else if (r < 14) ln = lim + 64'd1 + (64'($urandom) % (64'hFF_FFFF - lim));
      else if (r < 50) ln = 64'($urandom_range(1, 2 * bs_u));
      else if (r < 70) ln = 64'($urandom_range(1, LIMIT_BLOCKS)) << sh;
      else             ln = 64'($urandom_range(1, lim_u));
      ln_u = 32'(ln);
      r = $urandom_range(99);
      if (r < 25)      d = rand48() & ~(bs - 64'd1);
      else if (r < 35) d = ADDR_TOP - ln - 64'd1 + 64'($urandom_range(3));
      else             d = rand48();
      r = $urandom_range(99);
      if (r < 10)      s = d;
      else if (r < 30) s = d - 64'($urandom_range(1, ln_u));
      else if (r < 50) s = d + 64'($urandom_range(1, ln_u));
      else if (r < 60) s = $urandom_range(1) ? d + bs : d - bs;
      else if (r < 68) s = $urandom_range(1) ? d + bs - 64'd1 : d - bs + 64'd1;
      else if (r < 78) s = ADDR_TOP - ln - 64'd1 + 64'($urandom_range(3));
      else             s = $urandom_range(1) ? rand48() & ~(bs - 64'd1) : rand48();
    end
    send_request(op, d[ADDR_W-1:0], s[ADDR_W-1:0], ln[LEN_W-1:0]);
  endtask

  initial begin
    logic [SHIFT_W-1:0] shift_now;
    rst_n         = 1'b0;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    m_tready      = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    calm          = 1'b0;
    requests_sent = 0;
    idle_cycles   = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part at the reset block size of 4 KiB
    send_request(OP_READ,  48'h1000, 48'h0, 24'd0);
    send_request(OP_COPY,  48'h5_0123, 48'h5_0123, 24'd300);
    send_request(OP_READ,  48'h0, 48'h0, 24'd4096);
    send_request(OP_WRITE, 48'h2000, 48'hFFFF_FFFF_FFFF, 24'd8192);
    send_request(OP_ZERO,  48'h3000, 48'h0, 24'd12388);
    send_request(OP_WRITE, 48'h1_0F00, 48'h0, 24'd5000);
    send_request(OP_READ,  48'h7_0000, 48'h0, 24'd126976);
    send_request(OP_READ,  48'h0, 48'h0, 24'd126977);
    send_request(OP_WRITE, 48'h0, 48'h0, 24'hFF_FFFF);
    send_request(OP_ZERO,  48'hFFFF_FFFF_FFF0, 48'h0, 24'd16);
    send_request(OP_ZERO,  48'hFFFF_FFFF_FFF0, 48'h0, 24'd17);
    send_request(OP_READ,  48'hFFFF_FFFF_FFFF, 48'h0, 24'd1);
    send_request(OP_COPY,  48'h1000, 48'hFFFF_FFFF_FF9C, 24'd200);
    send_request(OP_COPY,  48'h1_0000, 48'h1_0064, 24'd10000);
    send_request(OP_COPY,  48'h2_0064, 48'h2_0000, 24'd10000);
    send_request(OP_COPY,  48'h3_2710, 48'h3_0000, 24'd10000);
    send_request(OP_COPY,  48'h4_1000, 48'h4_0000, 24'd20000);
    send_request(OP_COPY,  48'h5_0FFF, 48'h5_0000, 24'd20000);
    send_request(OP_COPY,  48'h8_0000, 48'h10_0000, 24'd20480);
    send_request(OP_COPY,  48'h9_0123, 48'hA_0F45, 24'd126976);
    send_request(OP_COPY,  48'hB_0F45, 48'hB_0123, 24'd126976);
    send_request(OP_COPY,  48'hFFFF_FFFF_FF00, 48'h0, 24'd256);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       shift_now = 5'd6;
        1:       shift_now = 5'd16;
        2:       shift_now = 5'd0;
        3:       shift_now = 5'd31;
        4:       shift_now = 5'd9;
        default: shift_now = 5'($urandom_range(31));
      endcase
      set_block_shift(shift_now);
      calm = (p == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // hold off now and then until the pipeline has drained
        if ($urandom_range(99) < 5)
          wait_drained();
        random_request(shift_now);
      end
      calm = 1'b0;
    end

    wait_drained();
    repeat (80) @(negedge clk);
    $display("sent %0d requests over %0d block size settings, checked %0d chunk results",
             requests_sent, PHASES + 1, chunks_seen);
    $display("all four commands, empty, refused, top-of-range and overlapping copies driven");
    if (mismatches == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: files.f
hdl/brcp_pkg.sv
hdl/brcp_ctrl.sv
hdl/brcp_datapath.sv
hdl/block_range_chunk_planner.sv
tb/sv/brcp_chunk_checker.sv
tb/sv/block_range_chunk_planner_tb.sv
